// ===== hdl/rema_pkg.sv =====
// ----------------------------------------------------------------------------
// rema_pkg: shared types and constants for the running EMA normalizer
// Single-precision operation codes, sequencer states and a helper function.
// ----------------------------------------------------------------------------
`default_nettype none
package rema_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DataW-1:0] MagicIsqrt = 32'h5F1F_FFF9;
  localparam logic [DataW-1:0] FloatOne = 32'h3F80_0000;
  localparam logic [DataW-1:0] MeanDecayRst = 32'h3F66_6666;
  localparam logic [DataW-1:0] VarDecayRst = 32'h3F66_6666;
  localparam logic [DataW-1:0] VarFloorRst = 32'h24E6_9595;
  localparam logic [DataW-1:0] MeanRst = 32'h0000_0000;
  localparam logic [DataW-1:0] VarRst = 32'h3F80_0000;
  localparam logic [DataW-1:0] FpDefaultNan = 32'hFFC0_0000;
  localparam logic [DataW-1:0] FpQuietBit = 32'h0040_0000;

  typedef enum logic [1:0] {
    REG_MEAN_DECAY = 2'd0,
    REG_VAR_DECAY  = 2'd1,
    REG_VAR_FLOOR  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_MUL = 1'b1
  } fp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T0,
    ST_T1,
    ST_T2,
    ST_M,
    ST_D,
    ST_U0,
    ST_U1,
    ST_U2,
    ST_U3,
    ST_V,
    ST_S,
    ST_Y,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic   start;
    fp_op_t op;
    logic   sub;
  } fp_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fp_stat_t;

  function automatic logic [DataW-1:0] approx_rsqrt(input logic [DataW-1:0] b);
    logic [DataW-1:0] half;
    half = {b[DataW-1], b[DataW-1:1]};
    return MagicIsqrt - half;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rema_if.sv =====
// ----------------------------------------------------------------------------
// rema_stream_if: valid/ready stream channel carrying one 32-bit word
// Source drives valid and data, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface rema_stream_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/running_ema_normalizer_core.sv =====
// ----------------------------------------------------------------------------
// running_ema_normalizer_core: EMA mean/variance sample normalizer
//
//   channel  dir  payload            transfer when
//   in       in   sample[31:0]       in.valid & in.ready
//   out      out  normalized[31:0]   out.valid & out.ready
//   cfg      in   cfg_idx, cfg_data  cfg_we
//
// Twelve dependent float ops run on one shared add/mul unit, each passing
// through issue, four unit stages and capture; the normalize stage is
// skipped when an operand is NaN or infinity or the exact result is zero.
// in.ready is high only while idle, so a new sample waits until the result
// is taken, and the result holds until then. Synchronous active-low reset
// loads defaults, mean 0.0, variance 1.0.
// ----------------------------------------------------------------------------
`default_nettype none
module running_ema_normalizer_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [rema_pkg::CfgIdxW-1:0]  cfg_idx,
  input  wire logic [rema_pkg::DataW-1:0]    cfg_data,
  rema_stream_if.sink                        in_ch,
  rema_stream_if.source                      out_ch
);
  import rema_pkg::*;

  fp_req_t     req;
  fp_stat_t    stat;
  logic [31:0] opa, opb, res;

  rema_seq u_seq (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .req, .opa, .opb, .stat, .res
  );

  rema_fpu u_fpu (
    .clk, .rst_n, .req, .a(opa), .b(opb), .stat, .res
  );
endmodule
`default_nettype wire

// ===== hdl/rema_fpu.sv =====
// ----------------------------------------------------------------------------
// rema_fpu: shared single-precision adder / multiplier
// Multicycle: operands captured, unpack, compute, normalize/round stages.
// ----------------------------------------------------------------------------
`default_nettype none
module rema_fpu (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire rema_pkg::fp_req_t       req,
  input  wire logic [31:0]             a,
  input  wire logic [31:0]             b,
  output rema_pkg::fp_stat_t           stat,
  output logic [31:0]                  res
);
  import rema_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_ALIGN, F_CALC, F_NORM, F_ROUND} fstate_t;

  fstate_t     fst_r, fst_nxt;
  fp_op_t      op_r;
  logic [31:0] a_r, b_r;
  logic        sgn_r, spc_r;
  logic [31:0] spc_val_r;
  logic signed [10:0] exp_r;
  logic [49:0] mag_r;     // wide mantissa workspace with sticky in bit 0
  logic [31:0] res_r;
  logic        done_r;

  // unpack
  logic        sa, sb;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  always_comb begin
    sa = a_r[31];
    sb = b_r[31];
    ea = a_r[30:23];
    eb = b_r[30:23];
    ma = {(ea != 8'd0), a_r[22:0]};
    mb = {(eb != 8'd0), b_r[22:0]};
    a_nan = (ea == 8'hFF) && (a_r[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (b_r[22:0] != 23'd0);
    a_inf = (ea == 8'hFF) && (a_r[22:0] == 23'd0);
    b_inf = (eb == 8'hFF) && (b_r[22:0] == 23'd0);
    a_zero = (a_r[30:0] == 31'd0);
    b_zero = (b_r[30:0] == 31'd0);
  end

  // effective exponents (denormals use 1)
  logic [7:0] ea_e, eb_e;
  assign ea_e = (ea == 8'd0) ? 8'd1 : ea;
  assign eb_e = (eb == 8'd0) ? 8'd1 : eb;

  // alignment for add
  logic        a_big;
  logic [7:0]  ediff;
  logic [49:0] big_m, sml_m, sml_sh;
  logic        sml_sticky;
  always_comb begin
    a_big = ({ea_e, ma} >= {eb_e, mb});
    ediff = a_big ? (ea_e - eb_e) : (eb_e - ea_e);
    big_m = a_big ? {1'b0, ma, 25'd0} : {1'b0, mb, 25'd0};
    sml_m = a_big ? {1'b0, mb, 25'd0} : {1'b0, ma, 25'd0};
    if (ediff >= 8'd50) begin
      sml_sh = 50'd0;
      sml_sticky = (sml_m != 50'd0);
    end else begin
      sml_sh = sml_m >> ediff;
      sml_sticky = ((sml_sh << ediff) != sml_m);
    end
  end

  // leading-zero count of workspace
  logic [5:0] lz;
  always_comb begin
    lz = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (mag_r[i]) lz = 6'(49 - i);
    end
  end

  // normalize: target leading one at bit 48, exponent tracks bit 48 weight
  logic signed [10:0] n_exp;
  logic [49:0] n_mag;
  logic        n_st;
  always_comb begin
    n_exp = exp_r;
    n_mag = mag_r;
    n_st = 1'b0;
    if (lz == 6'd0) begin
      n_mag = {1'b0, mag_r[49:1]};
      n_st = mag_r[0];
      n_exp = exp_r + 11'sd1;
    end else if (lz > 6'd1 && lz != 6'd50) begin
      n_mag = mag_r << (lz - 6'd1);
      n_exp = exp_r - 11'(signed'({5'd0, lz - 6'd1}));
    end
  end

  // subnormal denorm and rounding (from normalized regs)
  logic [49:0] d_mag;
  logic        d_st;
  logic [10:0] dsh;
  logic [23:0] kept;
  logic        g, st, lsb, rnd_up;
  logic [24:0] kr;
  logic [7:0]  fe;
  logic [31:0] packed_v;
  always_comb begin
    d_mag = mag_r;
    d_st = 1'b0;
    fe = 8'd0;
    if (exp_r < 11'sd1) begin
      dsh = 11'(11'sd1 - exp_r);
      if (dsh >= 11'd50) begin
        d_mag = 50'd0;
        d_st = (mag_r != 50'd0);
      end else begin
        d_mag = mag_r >> dsh;
        d_st = ((d_mag << dsh) != mag_r);
      end
    end else begin
      dsh = 11'd0;
    end
    kept = d_mag[48:25];
    g = d_mag[24];
    st = (d_mag[23:0] != 24'd0) | d_st;
    lsb = kept[0];
    rnd_up = g & (st | lsb);
    kr = {1'b0, kept} + {24'd0, rnd_up};
    if (kr[24]) begin
      // carry out: mantissa 1.0, exponent +1
      if (exp_r < 11'sd1) fe = 8'd2;
      else fe = 8'(exp_r + 11'sd1);
      packed_v = (exp_r >= 11'sd254) ? {sgn_r, 8'hFF, 23'd0} : {sgn_r, fe, 23'd0};
    end else if (exp_r < 11'sd1 || !kr[23]) begin
      packed_v = {sgn_r, 7'd0, kr[23], kr[22:0]};
    end else if (exp_r >= 11'sd255) begin
      packed_v = {sgn_r, 8'hFF, 23'd0};
    end else begin
      fe = 8'(exp_r);
      packed_v = {sgn_r, fe, kr[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      fst_r <= fst_nxt;
      done_r <= (fst_r == F_ROUND);
    end
  end

  always_comb begin
    fst_nxt = fst_r;
    unique case (fst_r)
      F_IDLE:  if (req.start) fst_nxt = F_ALIGN;
      F_ALIGN: fst_nxt = F_CALC;
      F_CALC:  fst_nxt = spc_r ? F_ROUND : F_NORM;
      F_NORM:  fst_nxt = F_ROUND;
      F_ROUND: fst_nxt = F_IDLE;
      default: fst_nxt = F_IDLE;
    endcase
  end

  logic [47:0] prod;
  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    case (fst_r)
      F_IDLE: if (req.start) begin
        a_r <= a;
        // a NaN subtrahend passes through with its own sign
        b_r <= (req.sub && !((b[30:23] == 8'hFF) && (b[22:0] != 23'd0))) ?
               {~b[31], b[30:0]} : b;
        op_r <= req.op;
      end
      F_ALIGN: begin
        spc_r <= 1'b0;
        if (op_r == OP_MUL) begin
          sgn_r <= sa ^ sb;
          if (a_nan) begin
            spc_r <= 1'b1; spc_val_r <= a_r | FpQuietBit;
          end else if (b_nan) begin
            spc_r <= 1'b1; spc_val_r <= b_r | FpQuietBit;
          end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            spc_r <= 1'b1; spc_val_r <= FpDefaultNan;
          end else if (a_inf || b_inf) begin
            spc_r <= 1'b1; spc_val_r <= {sa ^ sb, 8'hFF, 23'd0};
          end
          exp_r <= 11'(signed'({3'd0, ea_e})) + 11'(signed'({3'd0, eb_e})) - 11'sd127;
          mag_r <= {1'b0, prod, 1'b0};
        end else begin
          if (a_nan) begin
            spc_r <= 1'b1; spc_val_r <= a_r | FpQuietBit;
          end else if (b_nan) begin
            spc_r <= 1'b1; spc_val_r <= b_r | FpQuietBit;
          end else if (a_inf && b_inf && (sa != sb)) begin
            spc_r <= 1'b1; spc_val_r <= FpDefaultNan;
          end else if (a_inf) begin
            spc_r <= 1'b1; spc_val_r <= a_r;
          end else if (b_inf) begin
            spc_r <= 1'b1; spc_val_r <= b_r;
          end
          sgn_r <= a_big ? sa : sb;
          exp_r <= 11'(signed'({3'd0, (a_big ? ea_e : eb_e)}));
          if (sa == sb) mag_r <= big_m + (sml_sh | {49'd0, sml_sticky});
          else mag_r <= big_m - (sml_sh | {49'd0, sml_sticky});
        end
      end
      F_CALC: begin
        if (op_r == OP_ADD) begin
          // add workspace: leading one at 48 means bit 48 weight = 2^exp
          if (!spc_r && mag_r == 50'd0) begin
            spc_r <= 1'b1;
            spc_val_r <= {(sa & sb), 31'd0};
          end
        end else begin
          // product 2.46 at bits 48..1 -> weight of bit 48 = 2^(exp+1)
          mag_r <= {mag_r[48:0], 1'b0};
          if (!spc_r && mag_r == 50'd0) begin
            spc_r <= 1'b1; spc_val_r <= {sgn_r, 31'd0};
          end
        end
      end
      F_NORM: begin
        mag_r <= n_mag | {49'd0, n_st};
        exp_r <= n_exp;
      end
      F_ROUND: res_r <= spc_r ? spc_val_r : packed_v;
      default: ;
    endcase
  end

  assign stat.busy = (fst_r != F_IDLE);
  assign stat.done = done_r;
  assign res = res_r;
endmodule
`default_nettype wire

// ===== hdl/rema_seq.sv =====
// ----------------------------------------------------------------------------
// rema_seq: sequencer issuing the normalizer's float operations in order
// Holds state, config and temporaries; drives the shared FPU.
// ----------------------------------------------------------------------------
`default_nettype none
module rema_seq (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [rema_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire logic [31:0]                cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [31:0]                in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [31:0]                     out_data,
  output rema_pkg::fp_req_t               req,
  output logic [31:0]                     opa,
  output logic [31:0]                     opb,
  input  wire rema_pkg::fp_stat_t         stat,
  input  wire logic [31:0]                res
);
  import rema_pkg::*;

  seq_state_t st_r, st_nxt;
  logic issued_r, issued_nxt;
  logic [31:0] b1_r, b2_r, eps_r, m_r, v_r, x_r, t0_r, t1_r, t2_r, d_r, y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      issued_r <= 1'b0;
      b1_r <= MeanDecayRst;
      b2_r <= VarDecayRst;
      eps_r <= VarFloorRst;
      m_r <= MeanRst;
      v_r <= VarRst;
    end else begin
      st_r <= st_nxt;
      issued_r <= issued_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_MEAN_DECAY: b1_r <= cfg_data;
          REG_VAR_DECAY:  b2_r <= cfg_data;
          REG_VAR_FLOOR:  eps_r <= cfg_data;
          default: ;
        endcase
      end
      if (stat.done) begin
        unique case (st_r)
          ST_M: m_r <= res;
          ST_V: v_r <= res;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && in_valid) x_r <= in_data;
    if (stat.done) begin
      case (st_r)
        ST_T0, ST_U0: t0_r <= res;
        ST_T1, ST_U1: t1_r <= res;
        ST_T2, ST_U2, ST_U3: t2_r <= res;
        ST_D: d_r <= res;
        ST_S: t1_r <= approx_rsqrt(res);
        ST_Y: y_r <= res;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    issued_nxt = issued_r;
    req = '{start: 1'b0, op: OP_ADD, sub: 1'b0};
    opa = t0_r;
    opb = t2_r;
    in_ready = (st_r == ST_IDLE);
    out_valid = (st_r == ST_OUT);
    unique case (st_r)
      ST_T0: begin req.op = OP_MUL; opa = b1_r; opb = m_r; end
      ST_T1: begin req.sub = 1'b1; opa = FloatOne; opb = b1_r; end
      ST_T2: begin req.op = OP_MUL; opa = t1_r; opb = x_r; end
      ST_M:  begin opa = t0_r; opb = t2_r; end
      ST_D:  begin req.sub = 1'b1; opa = x_r; opb = m_r; end
      ST_U0: begin req.op = OP_MUL; opa = b2_r; opb = v_r; end
      ST_U1: begin req.sub = 1'b1; opa = FloatOne; opb = b2_r; end
      ST_U2: begin req.op = OP_MUL; opa = t1_r; opb = d_r; end
      ST_U3: begin req.op = OP_MUL; opa = t2_r; opb = d_r; end
      ST_V:  begin opa = t0_r; opb = t2_r; end
      ST_S:  begin opa = v_r; opb = eps_r; end
      ST_Y:  begin req.op = OP_MUL; opa = d_r; opb = t1_r; end
      default: ;
    endcase
    unique case (st_r)
      ST_IDLE: if (in_valid) st_nxt = ST_T0;
      ST_OUT:  if (out_ready) st_nxt = ST_IDLE;
      default: begin
        if (!issued_r && !stat.busy) begin
          req.start = 1'b1;
          issued_nxt = 1'b1;
        end
        if (stat.done) begin
          issued_nxt = 1'b0;
          st_nxt = seq_state_t'(st_r + 4'd1);
        end
      end
    endcase
  end

  assign out_data = y_r;
endmodule
`default_nettype wire

// ===== hdl/rema_checker.sv =====
// ----------------------------------------------------------------------------
// rema_checker: port-level checks for the normalizer core
// Watches handshakes and transfer ordering.
// ----------------------------------------------------------------------------
`default_nettype none
module rema_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_data
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready right after transfer");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind running_ema_normalizer_core rema_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

// ===== sim/tb_running_ema_normalizer_core.sv =====
// ----------------------------------------------------------------------------
// tb_running_ema_normalizer_core: self-checking bench for the EMA normalizer
// A bit-exact single-precision model of the mean/variance update and the
// inverse square root estimate predicts every normalized sample. Directed
// extremes, then random samples under several register settings, with random
// idle bursts on both channels. Samples that lock NaN or infinity into the
// running state are saved for the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_running_ema_normalizer_core;
  import rema_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] QuietBit = 32'h0040_0000;
  localparam int WatchdogLimit = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [DataW-1:0] cfg_data = '0;

  rema_stream_if in_ch ();
  rema_stream_if out_ch ();

  running_ema_normalizer_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  always #5 clk = ~clk;

  logic [31:0] mean_decay_q, var_decay_q, var_floor_q;
  logic [31:0] mean_q, var_q;
  logic [31:0] sample_queue[$];
  logic [31:0] normalized_queue[$];
  int errors = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit calm = 1'b0;

  function automatic bit is_nan(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != 0;
  endfunction

  function automatic bit is_inf(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] == 0;
  endfunction

  function automatic logic [71:0] mant_of(logic [31:0] a);
    return (a[30:23] == 0) ? 72'(a[22:0]) : 72'({1'b1, a[22:0]});
  endfunction

  function automatic int exp_of(logic [31:0] a);
    return ((a[30:23] == 0) ? 1 : int'(a[30:23])) - 150;
  endfunction

  // value = sig * 2^e, rounded to nearest even
  function automatic logic [31:0] fp_round(logic s, int e, logic [71:0] sig);
    int p, sh, w;
    logic [71:0] kept;
    logic g, st;
    p = 0;
    for (int i = 0; i < 72; i++) if (sig[i]) p = i;
    sh = (p + e + 127 >= 1) ? p - 23 : -149 - e;
    if (sh > 71) begin
      kept = 0;
      g = 1'b0;
      st = 1'b1;
    end else if (sh > 0) begin
      kept = sig >> sh;
      g = sig[sh-1];
      st = (sh > 1) ? |(sig & ((72'd1 << (sh - 1)) - 1)) : 1'b0;
    end else begin
      kept = sig << (-sh);
      g = 1'b0;
      st = 1'b0;
    end
    if (g && (st || kept[0])) kept = kept + 1;
    w = e + sh;
    if (kept[24]) begin
      kept = kept >> 1;
      w++;
    end
    if (!kept[23]) return {s, 8'd0, kept[22:0]};
    if (w + 150 >= 255) return {s, 8'hFF, 23'd0};
    return {s, 8'(w + 150), kept[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic s;
    if (is_nan(a)) return a | QuietBit;
    if (is_nan(b)) return b | QuietBit;
    s = a[31] ^ b[31];
    if (is_inf(a)) return (b[30:0] == 0) ? DefaultNan : {s, 8'hFF, 23'd0};
    if (is_inf(b)) return (a[30:0] == 0) ? DefaultNan : {s, 8'hFF, 23'd0};
    if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
    return fp_round(s, exp_of(a) + exp_of(b), mant_of(a) * mant_of(b));
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b, bit negate);
    logic [31:0] t;
    logic [71:0] big, lit;
    int e, diff;
    if (is_nan(a)) return a | QuietBit;
    if (is_nan(b)) return b | QuietBit;
    if (negate) b[31] = ~b[31];
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? DefaultNan : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 0) return b;
    if (b[30:0] == 0) return a;
    if (exp_of(b) > exp_of(a)) begin
      t = a;
      a = b;
      b = t;
    end
    diff = exp_of(a) - exp_of(b);
    if (diff <= 40) begin
      big = mant_of(a) << diff;
      lit = mant_of(b);
      e = exp_of(b);
    end else begin
      big = mant_of(a) << 3;
      lit = 72'd1;
      e = exp_of(a) - 3;
    end
    if (a[31] == b[31]) return fp_round(a[31], e, big + lit);
    if (big > lit) return fp_round(a[31], e, big - lit);
    if (lit > big) return fp_round(b[31], e, lit - big);
    return 32'd0;
  endfunction

  function automatic logic [31:0] normalize_sample(logic [31:0] x);
    logic [31:0] t0, t1, t2, m, d, v, s, r;
    t0 = fp_mul(mean_decay_q, mean_q);
    t1 = fp_add(FloatOne, mean_decay_q, 1'b1);
    t2 = fp_mul(t1, x);
    m = fp_add(t0, t2, 1'b0);
    d = fp_add(x, m, 1'b1);
    t0 = fp_mul(var_decay_q, var_q);
    t1 = fp_add(FloatOne, var_decay_q, 1'b1);
    t2 = fp_mul(t1, d);
    t2 = fp_mul(t2, d);
    v = fp_add(t0, t2, 1'b0);
    s = fp_add(v, var_floor_q, 1'b0);
    r = MagicIsqrt - {s[31], s[31:1]};
    mean_q = m;
    var_q = v;
    return fp_mul(d, r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %08h expected %08h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // input side: transfer bookkeeping and random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        normalized_queue.push_back(normalize_sample(in_ch.data));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          in_ch.data <= sample_queue.pop_front();
          in_ch.valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 14);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side: compare and random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (normalized_queue.size() == 0) begin
          report_mismatch("unexpected result", out_ch.data, 32'd0);
        end else begin
          logic [31:0] want;
          want = normalized_queue.pop_front();
          if (out_ch.data !== want) report_mismatch("normalized", out_ch.data, want);
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    if (idx == REG_MEAN_DECAY) mean_decay_q = val;
    else if (idx == REG_VAR_DECAY) var_decay_q = val;
    else if (idx == REG_VAR_FLOOR) var_floor_q = val;
  endtask

  task automatic set_decays(input logic [31:0] md, input logic [31:0] vd,
                            input logic [31:0] fl);
    write_reg(REG_MEAN_DECAY, md);
    write_reg(REG_VAR_DECAY, vd);
    write_reg(REG_VAR_FLOOR, fl);
    write_reg(RegUnused, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (sample_queue.size() > 0 || in_ch.valid || normalized_queue.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // finite samples with magnitudes that keep the squared deviation finite
  function automatic logic [31:0] rand_sample();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
    if (k == 7) return {1'($urandom), 8'($urandom_range(0, 3)), 23'($urandom)};
    return {1'($urandom), 8'($urandom_range(0, 8'hBE)), 23'($urandom)};
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) sample_queue.push_back(rand_sample());
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    mean_decay_q = MeanDecayRst;
    var_decay_q = VarDecayRst;
    var_floor_q = VarFloorRst;
    mean_q = MeanRst;
    var_q = VarRst;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed, finite values first
    sample_queue.push_back(32'h0000_0000);
    sample_queue.push_back(32'h8000_0000);
    sample_queue.push_back(32'h3F80_0000);
    sample_queue.push_back(32'hBF80_0000);
    sample_queue.push_back(32'h0000_0001);
    sample_queue.push_back(32'h8000_0001);
    sample_queue.push_back(32'h007F_FFFF);
    sample_queue.push_back(32'h0080_0000);
    sample_queue.push_back(32'h5EFF_FFFF);
    sample_queue.push_back(32'hDEFF_FFFF);
    sample_queue.push_back(32'h3F80_0000);
    sample_queue.push_back(32'h3F80_0000);
    drain();

    run_random(200);
    set_decays(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    sample_queue.push_back(32'h4040_0000);
    sample_queue.push_back(32'h0000_0000);
    run_random(120);
    set_decays(32'h3F80_0000, 32'h3F00_0000, 32'h7F7F_FFFF);
    run_random(120);
    set_decays(32'h3F7F_FFFF, 32'h3F80_0000, 32'hBF80_0000);
    run_random(120);
    set_decays(32'h3E80_0000, 32'h3F40_0000, 32'hFFFF_FFFF);
    run_random(120);
    set_decays(32'h3F66_6666, 32'h3F66_6666, 32'h24E6_9595);
    calm = 1'b1;
    run_random(200);

    // samples that lock infinity or NaN into the running state
    sample_queue.push_back(32'h7F7F_FFFF);
    sample_queue.push_back(32'hFF7F_FFFF);
    sample_queue.push_back(32'h7F80_0000);
    sample_queue.push_back(32'hFF80_0000);
    sample_queue.push_back(32'h7F80_0001);
    sample_queue.push_back(32'h7FC0_0000);
    sample_queue.push_back(32'hFFFF_FFFF);
    drain();
    set_decays(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    sample_queue.push_back(32'h3F80_0000);
    sample_queue.push_back(32'h0000_0000);
    drain();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rema_pkg.sv
hdl/rema_if.sv
hdl/rema_fpu.sv
hdl/rema_seq.sv
hdl/running_ema_normalizer_core.sv
hdl/rema_checker.sv
sim/tb_running_ema_normalizer_core.sv
